// ----- rtl/crc8_packet_deframer_core_defines.svh -----
// Assertion macros shared by the deframer RTL.
// Defining ASSERT_OFF turns every macro below into an empty body.
`ifndef CRC8_PACKET_DEFRAMER_CORE_DEFINES_SVH
`define CRC8_PACKET_DEFRAMER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at each rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("implication check failed");

// Next-cycle implication, checked at each rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, cond, expr)
`define ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

// ----- rtl/c8pd_pkg.sv -----
`timescale 1ns / 1ps
// Types, constants and the CRC-8 byte step for the packet deframer.
// No dependencies; used by the channel interfaces and the top level.
package c8pd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned INDEX_W = 7;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] SYNC1_BYTE = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC2_BYTE = 8'h55;
    localparam logic [BYTE_W-1:0] CRC_POLY   = 8'h07;
    localparam logic [BYTE_W-1:0] CRC_MSB    = 8'h80;
    localparam logic [BYTE_W-1:0] MIN_SIZE   = 8'd2;

    localparam logic [INDEX_W-1:0] IDX_SYNC2 = 7'd1;
    localparam logic [INDEX_W-1:0] IDX_SIZE  = 7'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MASK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_CODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENDPOINT_MASK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUTER_MASK   = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_SIZE    = 3'd2,
        PH_CMD     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC     = 3'd5
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               is_verdict;
        logic               crc_good;
        logic               to_forward;
        logic               to_internal;
        logic               aborted;
    } result_t;

    // One byte through CRC-8, MSB first, unrolled over its eight bits.
    function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int i = 0; i < BYTE_W; i++) begin
            if ((c & CRC_MSB) != '0)
            begin
                c = (c << 1) ^ CRC_POLY;
            end
            else
            begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/c8pd_in_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel that carries one received link byte per item.
// Depends on c8pd_pkg for the byte width.
interface c8pd_in_if;
    logic                         valid;
    logic                         ready;
    logic [c8pd_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/c8pd_out_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel that carries one deframer result per item.
// Depends on c8pd_pkg for the field widths.
interface c8pd_out_if;
    logic                         valid;
    logic                         ready;
    logic [c8pd_pkg::BYTE_W-1:0]  out_byte;
    logic [c8pd_pkg::INDEX_W-1:0] byte_index;
    logic                         is_verdict;
    logic                         crc_good;
    logic                         to_forward;
    logic                         to_internal;
    logic                         aborted;

    modport source (output valid, output out_byte, output byte_index, output is_verdict,
                    output crc_good, output to_forward, output to_internal,
                    output aborted, input ready);
    modport sink   (input valid, input out_byte, input byte_index, input is_verdict,
                    input crc_good, input to_forward, input to_internal,
                    input aborted, output ready);
endinterface

// ----- rtl/crc8_packet_deframer_core.sv -----
`timescale 1ns / 1ps
// Channel    Dir  Carries
// rx_ch      in   rx_byte, one received byte per item
// tx_ch      out  out_byte, byte_index, is_verdict, crc_good, to_forward, to_internal,
//                 aborted
// cfg_*      in   register writes: source mask, origin code, endpoint and router masks
//
// The frame state and the result register update at the edge that takes a byte, so
// bytes stream at one per cycle while results are taken. The result register is the
// only stage between the sides: a new byte is taken while the result waits, as long
// as that result is taken in the same cycle. Idle noise bytes produce no item.
// Reset clears the state machine, counters, CRC and all four registers.
// Frame receiver for 0xAA 0x55 size command payload CRC-8 frames.
// Depends on c8pd_pkg, c8pd_in_if, c8pd_out_if and the assertion macro header.
`include "crc8_packet_deframer_core_defines.svh"

module crc8_packet_deframer_core #(
    parameter int unsigned MAX_LEN = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [c8pd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [c8pd_pkg::BYTE_W-1:0]     cfg_data,
    c8pd_in_if.sink                         rx_ch,
    c8pd_out_if.source                      tx_ch
);

    // The counter has to reach size + 3 for the largest size allowed.
    localparam int unsigned CNT_W = $clog2(MAX_LEN + 4);
    localparam logic [c8pd_pkg::BYTE_W-1:0] MAX_SIZE = c8pd_pkg::BYTE_W'(MAX_LEN);

    logic [c8pd_pkg::BYTE_W-1:0] source_mask_reg;
    logic [c8pd_pkg::BYTE_W-1:0] origin_code_reg;
    logic [c8pd_pkg::BYTE_W-1:0] endpoint_mask_reg;
    logic [c8pd_pkg::BYTE_W-1:0] router_mask_reg;

    c8pd_pkg::phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]            byte_count_reg, byte_count_next;
    logic [CNT_W-1:0]            frame_total_reg, frame_total_next;
    logic [c8pd_pkg::BYTE_W-1:0] crc_reg, crc_next;
    logic [c8pd_pkg::BYTE_W-1:0] cmd_reg, cmd_next;

    logic                        tx_valid_reg;
    c8pd_pkg::result_t           res_reg;
    c8pd_pkg::result_t           res_next;
    logic                        emit;

    logic                        accept;
    logic [c8pd_pkg::BYTE_W-1:0] b;
    logic [c8pd_pkg::BYTE_W-1:0] cmd_rewritten;
    logic [CNT_W-1:0]            count_inc;
    logic [CNT_W-1:0]            last_data;
    logic                        good;

    assign rx_ch.ready   = !tx_valid_reg || tx_ch.ready;
    assign accept        = rx_ch.valid && rx_ch.ready;
    assign b             = rx_ch.rx_byte;
    assign cmd_rewritten = (b & ~source_mask_reg) | origin_code_reg;
    assign count_inc     = byte_count_reg + CNT_W'(1);
    assign last_data     = frame_total_reg - CNT_W'(1);
    assign good          = (crc_reg == b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_mask_reg   <= '0;
            origin_code_reg   <= '0;
            endpoint_mask_reg <= '0;
            router_mask_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                c8pd_pkg::CFG_SOURCE_MASK:   source_mask_reg   <= cfg_data;
                c8pd_pkg::CFG_ORIGIN_CODE:   origin_code_reg   <= cfg_data;
                c8pd_pkg::CFG_ENDPOINT_MASK: endpoint_mask_reg <= cfg_data;
                c8pd_pkg::CFG_ROUTER_MASK:   router_mask_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Next frame state for the byte at the input.
    always_comb
    begin
        phase_next       = phase_reg;
        byte_count_next  = byte_count_reg;
        frame_total_next = frame_total_reg;
        crc_next         = crc_reg;
        cmd_next         = cmd_reg;
        case (phase_reg)
            c8pd_pkg::PH_IDLE:
            begin
                if (b == c8pd_pkg::SYNC1_BYTE)
                begin
                    byte_count_next = CNT_W'(1);
                    phase_next      = c8pd_pkg::PH_SYNC2;
                end
            end
            c8pd_pkg::PH_SYNC2:
            begin
                if (b != c8pd_pkg::SYNC2_BYTE)
                begin
                    phase_next = c8pd_pkg::PH_IDLE;
                end
                else
                begin
                    byte_count_next = CNT_W'(2);
                    phase_next      = c8pd_pkg::PH_SIZE;
                end
            end
            c8pd_pkg::PH_SIZE:
            begin
                if (b < c8pd_pkg::MIN_SIZE || b > MAX_SIZE)
                begin
                    phase_next = c8pd_pkg::PH_IDLE;
                end
                else
                begin
                    byte_count_next  = CNT_W'(3);
                    frame_total_next = CNT_W'(b) + CNT_W'(3);
                    crc_next         = c8pd_pkg::crc8_step('0, b);
                    phase_next       = c8pd_pkg::PH_CMD;
                end
            end
            c8pd_pkg::PH_CMD:
            begin
                cmd_next        = cmd_rewritten;
                crc_next        = c8pd_pkg::crc8_step(crc_reg, cmd_rewritten);
                byte_count_next = count_inc;
                phase_next      = (count_inc < last_data) ? c8pd_pkg::PH_PAYLOAD
                                                          : c8pd_pkg::PH_CRC;
            end
            c8pd_pkg::PH_PAYLOAD:
            begin
                crc_next        = c8pd_pkg::crc8_step(crc_reg, b);
                byte_count_next = count_inc;
                if (count_inc >= last_data)
                begin
                    phase_next = c8pd_pkg::PH_CRC;
                end
            end
            c8pd_pkg::PH_CRC:
            begin
                phase_next = c8pd_pkg::PH_IDLE;
            end
            default:
            begin
                phase_next = c8pd_pkg::PH_IDLE;
            end
        endcase
    end

    // Result for the byte at the input.
    always_comb
    begin
        res_next            = '0;
        res_next.out_byte   = b;
        res_next.byte_index = c8pd_pkg::INDEX_W'(byte_count_reg);
        emit                = 1'b1;
        case (phase_reg)
            c8pd_pkg::PH_IDLE:
            begin
                res_next.byte_index = '0;
                emit                = (b == c8pd_pkg::SYNC1_BYTE);
            end
            c8pd_pkg::PH_SYNC2:
            begin
                res_next.byte_index = c8pd_pkg::IDX_SYNC2;
                res_next.aborted    = (b != c8pd_pkg::SYNC2_BYTE);
            end
            c8pd_pkg::PH_SIZE:
            begin
                res_next.byte_index = c8pd_pkg::IDX_SIZE;
                res_next.aborted    = (b < c8pd_pkg::MIN_SIZE || b > MAX_SIZE);
            end
            c8pd_pkg::PH_CMD:
            begin
                res_next.out_byte = cmd_rewritten;
            end
            c8pd_pkg::PH_PAYLOAD: ;
            c8pd_pkg::PH_CRC:
            begin
                res_next.is_verdict  = 1'b1;
                res_next.crc_good    = good;
                res_next.to_forward  = good && ((cmd_reg & endpoint_mask_reg) != '0);
                res_next.to_internal = good && ((cmd_reg & router_mask_reg) != '0);
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= c8pd_pkg::PH_IDLE;
            byte_count_reg  <= '0;
            frame_total_reg <= '0;
            crc_reg         <= '0;
            cmd_reg         <= '0;
            tx_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg       <= phase_next;
                byte_count_reg  <= byte_count_next;
                frame_total_reg <= frame_total_next;
                crc_reg         <= crc_next;
                cmd_reg         <= cmd_next;
            end
            if (accept && emit)
            begin
                tx_valid_reg <= 1'b1;
            end
            else if (tx_ch.ready)
            begin
                tx_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign tx_ch.valid       = tx_valid_reg;
    assign tx_ch.out_byte    = res_reg.out_byte;
    assign tx_ch.byte_index  = res_reg.byte_index;
    assign tx_ch.is_verdict  = res_reg.is_verdict;
    assign tx_ch.crc_good    = res_reg.crc_good;
    assign tx_ch.to_forward  = res_reg.to_forward;
    assign tx_ch.to_internal = res_reg.to_internal;
    assign tx_ch.aborted     = res_reg.aborted;

    // A start byte seen while idle opens a frame and is shown as its first byte.
    `ASSERT_NEXT(a_frame_start, clk, rst_n, accept && phase_reg == c8pd_pkg::PH_IDLE && b == c8pd_pkg::SYNC1_BYTE, phase_reg == c8pd_pkg::PH_SYNC2 && tx_valid_reg && res_reg.byte_index == '0)
    // Inside the data part of a frame the count stays short of the frame length.
    `ASSERT_IMPL(a_count_bound, clk, rst_n, phase_reg == c8pd_pkg::PH_PAYLOAD || phase_reg == c8pd_pkg::PH_CRC, byte_count_reg <= last_data)
    // Routing flags only come with a passing CRC on a verdict.
    `ASSERT_IMPL(a_flags_need_good, clk, rst_n, tx_valid_reg && (res_reg.to_forward || res_reg.to_internal), res_reg.is_verdict && res_reg.crc_good)
    // A dropped frame never carries a verdict.
    `ASSERT_IMPL(a_abort_no_verdict, clk, rst_n, tx_valid_reg && res_reg.aborted, !res_reg.is_verdict && phase_reg == c8pd_pkg::PH_IDLE)

endmodule

// ----- test/deframe_tb_pkg.sv -----
`timescale 1ns / 1ps
// CRC-8 helper shared by the deframer stimulus and its scoreboard.
// Depends on c8pd_pkg for the byte width and the polynomial.
package deframe_tb_pkg;

    // CRC-8 over one byte, bit-serial form: each message bit enters at the top.
    function automatic logic [c8pd_pkg::BYTE_W-1:0] crc8_bitwise(
        input logic [c8pd_pkg::BYTE_W-1:0] crc,
        input logic [c8pd_pkg::BYTE_W-1:0] data
    );
        logic [c8pd_pkg::BYTE_W-1:0] acc;
        logic                        fb;
        acc = crc;
        for (int i = c8pd_pkg::BYTE_W - 1; i >= 0; i--)
        begin
            fb  = acc[c8pd_pkg::BYTE_W-1] ^ data[i];
            acc = {acc[c8pd_pkg::BYTE_W-2:0], 1'b0} ^ (fb ? c8pd_pkg::CRC_POLY : '0);
        end
        return acc;
    endfunction

endpackage

// ----- test/deframe_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the CRC-8 packet deframer: watches the byte channel, the result
// channel and the register port, predicts every result and compares it field by field.
// Depends on c8pd_pkg, deframe_tb_pkg and the two channel interfaces.
module deframe_checker #(
    parameter int MAX_LEN = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [c8pd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [c8pd_pkg::BYTE_W-1:0]    cfg_data,
    c8pd_in_if                             rx,
    c8pd_out_if                            tx,
    output int                             fail_count,
    output int                             exp_pending,
    output int                             n_results,
    output int                             n_good,
    output int                             n_bad_crc,
    output int                             n_abort
);
    import c8pd_pkg::*;
    import deframe_tb_pkg::*;

    localparam int MAX_REPORTS = 10;

    // Register copies, updated from the write port.
    logic [BYTE_W-1:0] src_mask;
    logic [BYTE_W-1:0] origin;
    logic [BYTE_W-1:0] fwd_mask;
    logic [BYTE_W-1:0] int_mask;

    // Frame state of the predictor.
    phase_t            frm_phase;
    int                frm_pos;
    int                frm_total;
    logic [BYTE_W-1:0] frm_crc;
    logic [BYTE_W-1:0] frm_cmd;

    result_t expected_results[$];
    int      n_fail;
    int      n_seen;
    int      n_ok;
    int      n_bad;
    int      n_drop;

    assign fail_count = n_fail;
    assign n_results  = n_seen;
    assign n_good     = n_ok;
    assign n_bad_crc  = n_bad;
    assign n_abort    = n_drop;

    // Advances the frame state by one received byte; returns 1 when a result follows.
    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output result_t r);
        logic [BYTE_W-1:0] cmd;
        logic              good;
        r            = '0;
        r.out_byte   = b;
        deframe_byte = 1'b1;
        case (frm_phase)
            PH_IDLE:
            begin
                if (b != SYNC1_BYTE)
                begin
                    deframe_byte = 1'b0;
                end
                else
                begin
                    frm_pos   = 1;
                    frm_phase = PH_SYNC2;
                end
            end
            PH_SYNC2:
            begin
                r.byte_index = IDX_SYNC2;
                if (b != SYNC2_BYTE)
                begin
                    r.aborted = 1'b1;
                    frm_phase = PH_IDLE;
                end
                else
                begin
                    frm_pos   = 2;
                    frm_phase = PH_SIZE;
                end
            end
            PH_SIZE:
            begin
                r.byte_index = IDX_SIZE;
                if (b < MIN_SIZE || int'(b) > MAX_LEN)
                begin
                    r.aborted = 1'b1;
                    frm_phase = PH_IDLE;
                end
                else
                begin
                    frm_pos   = 3;
                    frm_total = int'(b) + 3;
                    frm_crc   = crc8_bitwise('0, b);
                    frm_phase = PH_CMD;
                end
            end
            PH_CMD:
            begin
                // The origin code is ORed in whole, even outside the source bits.
                cmd          = (b & ~src_mask) | origin;
                frm_cmd      = cmd;
                frm_crc      = crc8_bitwise(frm_crc, cmd);
                r.out_byte   = cmd;
                r.byte_index = INDEX_W'(frm_pos);
                frm_pos++;
                frm_phase    = (frm_pos < frm_total - 1) ? PH_PAYLOAD : PH_CRC;
            end
            PH_PAYLOAD:
            begin
                frm_crc      = crc8_bitwise(frm_crc, b);
                r.byte_index = INDEX_W'(frm_pos);
                frm_pos++;
                if (frm_pos >= frm_total - 1)
                begin
                    frm_phase = PH_CRC;
                end
            end
            PH_CRC:
            begin
                good          = (frm_crc == b);
                r.byte_index  = INDEX_W'(frm_pos);
                r.is_verdict  = 1'b1;
                r.crc_good    = good;
                r.to_forward  = good && ((frm_cmd & fwd_mask) != '0);
                r.to_internal = good && ((frm_cmd & int_mask) != '0);
                frm_phase     = PH_IDLE;
            end
            default:
            begin
                deframe_byte = 1'b0;
                frm_phase    = PH_IDLE;
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t seen;
        if (!rst_n)
        begin
            src_mask  = '0;
            origin    = '0;
            fwd_mask  = '0;
            int_mask  = '0;
            frm_phase = PH_IDLE;
            frm_pos   = 0;
            frm_total = 0;
            frm_crc   = '0;
            frm_cmd   = '0;
            expected_results.delete();
            n_fail    = 0;
            n_seen    = 0;
            n_ok      = 0;
            n_bad     = 0;
            n_drop    = 0;
            exp_pending <= 0;
        end
        else
        begin
            // A result taken at this edge belongs to an earlier byte, so compare first.
            if (tx.valid && tx.ready)
            begin
                seen = '{tx.out_byte, tx.byte_index, tx.is_verdict, tx.crc_good,
                         tx.to_forward, tx.to_internal, tx.aborted};
                n_seen++;
                if (expected_results.size() == 0)
                begin
                    if (n_fail < MAX_REPORTS)
                    begin
                        $display("%0t: result with nothing pending: byte=%02h idx=%0d",
                                 $realtime, seen.out_byte, seen.byte_index);
                    end
                    n_fail++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (seen.out_byte !== want.out_byte
                        || seen.byte_index !== want.byte_index
                        || seen.is_verdict !== want.is_verdict
                        || seen.crc_good !== want.crc_good
                        || seen.to_forward !== want.to_forward
                        || seen.to_internal !== want.to_internal
                        || seen.aborted !== want.aborted)
                    begin
                        if (n_fail < MAX_REPORTS)
                        begin
                            $display("%0t: mismatch: expected byte=%02h idx=%0d v=%b g=%b f=%b i=%b a=%b",
                                     $realtime, want.out_byte, want.byte_index, want.is_verdict,
                                     want.crc_good, want.to_forward, want.to_internal,
                                     want.aborted);
                            $display("%0t:           got      byte=%02h idx=%0d v=%b g=%b f=%b i=%b a=%b",
                                     $realtime, seen.out_byte, seen.byte_index, seen.is_verdict,
                                     seen.crc_good, seen.to_forward, seen.to_internal,
                                     seen.aborted);
                        end
                        n_fail++;
                    end
                    if (want.is_verdict && want.crc_good)
                    begin
                        n_ok++;
                    end
                    if (want.is_verdict && !want.crc_good)
                    begin
                        n_bad++;
                    end
                    if (want.aborted)
                    begin
                        n_drop++;
                    end
                end
            end
            if (rx.valid && rx.ready)
            begin
                if (deframe_byte(rx.rx_byte, want))
                begin
                    expected_results.push_back(want);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SOURCE_MASK:   src_mask = cfg_data;
                    CFG_ORIGIN_CODE:   origin   = cfg_data;
                    CFG_ENDPOINT_MASK: fwd_mask = cfg_data;
                    CFG_ROUTER_MASK:   int_mask = cfg_data;
                    default:           ;
                endcase
            end
            exp_pending <= expected_results.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the CRC-8 packet deframer testbench: clock, reset, register writes, byte
// stimulus with random idling, output stalls, watchdog and the final verdict.
// Depends on c8pd_pkg, deframe_tb_pkg, the channel interfaces and deframe_checker.
module tb_top;
    import c8pd_pkg::*;
    import deframe_tb_pkg::*;

    localparam int MAX_LEN        = 64;
    localparam int N_PHASES       = 6;
    localparam int ITEMS_PER_PHASE = 45;
    localparam int LONG_HOLD      = 60;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;

    c8pd_in_if  rx_if ();
    c8pd_out_if tx_if ();

    // Register values as last written, needed to build frames with a good CRC.
    logic [BYTE_W-1:0] cur_src;
    logic [BYTE_W-1:0] cur_org;

    bit gap_en;
    bit stall_en;
    bit hold_req;
    int n_sent;
    int n_settings;

    int fail_count;
    int exp_pending;
    int n_results;
    int n_good;
    int n_bad_crc;
    int n_abort;

    crc8_packet_deframer_core #(
        .MAX_LEN (MAX_LEN)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_ch     (rx_if),
        .tx_ch     (tx_if)
    );

    deframe_checker #(
        .MAX_LEN (MAX_LEN)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .rx          (rx_if),
        .tx          (tx_if),
        .fail_count  (fail_count),
        .exp_pending (exp_pending),
        .n_results   (n_results),
        .n_good      (n_good),
        .n_bad_crc   (n_bad_crc),
        .n_abort     (n_abort)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: ready drops in short random bursts, or for a long stretch on request.
    initial
    begin : result_sink
        int n;
        tx_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                tx_if.ready <= 1'b0;
                hold_req = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (stall_en && $urandom_range(0, 4) == 0)
            begin
                tx_if.ready <= 1'b0;
                n = $urandom_range(1, 3);
                repeat (n - 1) @(negedge clk);
            end
            else
            begin
                tx_if.ready <= 1'b1;
            end
        end
    end

    // Ends the run if neither channel moves an item for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offers one byte, with an optional idle burst first, and waits until it is taken.
    // Called and returns at a falling edge; valid stays high for the next byte.
    task automatic drive_byte(input logic [BYTE_W-1:0] b, input bit counted);
        int n;
        if (gap_en && $urandom_range(0, 5) == 0)
        begin
            rx_if.valid <= 1'b0;
            n = $urandom_range(1, 3);
            repeat (n) @(negedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (!(rx_if.valid === 1'b1 && rx_if.ready === 1'b1));
        @(negedge clk);
        if (counted)
        begin
            n_sent++;
        end
    endtask

    // Sends a frame of the given size; keep > 0 cuts it short after that many bytes.
    task automatic send_frame(input int size, input logic [BYTE_W-1:0] cmd,
                              input bit crc_ok, input int keep);
        logic [BYTE_W-1:0] bytes[$];
        logic [BYTE_W-1:0] crc;
        logic [BYTE_W-1:0] pl;
        int                n;
        bytes = {SYNC1_BYTE, SYNC2_BYTE, BYTE_W'(size), cmd};
        crc   = crc8_bitwise('0, BYTE_W'(size));
        crc   = crc8_bitwise(crc, (cmd & ~cur_src) | cur_org);
        repeat (size - 2)
        begin
            pl  = BYTE_W'($urandom);
            crc = crc8_bitwise(crc, pl);
            bytes.push_back(pl);
        end
        bytes.push_back(crc_ok ? crc : crc ^ BYTE_W'($urandom_range(1, 255)));
        n = (keep > 0) ? keep : bytes.size();
        for (int i = 0; i < n; i++)
        begin
            drive_byte(bytes[i], 1'b1);
        end
    endtask

    // Mostly short frames, some medium ones and a few at the size limit.
    function automatic int frame_size();
        int p;
        p = $urandom_range(0, 19);
        if (p < 15)
        begin
            return $urandom_range(2, 8);
        end
        else if (p < 18)
        begin
            return $urandom_range(9, MAX_LEN - 1);
        end
        return MAX_LEN;
    endfunction

    task automatic send_bad_sync();
        logic [BYTE_W-1:0] b;
        b = ($urandom_range(0, 3) == 0) ? SYNC1_BYTE
                                        : SYNC2_BYTE ^ BYTE_W'($urandom_range(1, 255));
        drive_byte(SYNC1_BYTE, 1'b1);
        drive_byte(b, 1'b1);
    endtask

    task automatic send_bad_size();
        logic [BYTE_W-1:0] sz;
        sz = ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom_range(0, 1))
                                         : BYTE_W'($urandom_range(MAX_LEN + 1, 255));
        drive_byte(SYNC1_BYTE, 1'b1);
        drive_byte(SYNC2_BYTE, 1'b1);
        drive_byte(sz, 1'b1);
    endtask

    task automatic random_traffic(input int target, input bit with_hold);
        int pick;
        int size;
        int first;
        bit held;
        held  = 1'b0;
        first = n_sent;
        while (n_sent - first < target)
        begin
            if (with_hold && !held && n_sent - first > target / 2)
            begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            pick = $urandom_range(0, 99);
            size = frame_size();
            if (pick < 70)
            begin
                send_frame(size, BYTE_W'($urandom), $urandom_range(0, 4) != 0, 0);
            end
            else if (pick < 78)
            begin
                send_bad_sync();
            end
            else if (pick < 86)
            begin
                send_bad_size();
            end
            else if (pick < 93)
            begin
                repeat ($urandom_range(1, 4)) drive_byte(BYTE_W'($urandom), 1'b0);
            end
            else
            begin
                // The cut frame swallows the start of whatever follows.
                send_frame(size, BYTE_W'($urandom), 1'b1, $urandom_range(3, size + 2));
            end
        end
    endtask

    // Zero bytes complete any open frame (at most MAX_LEN + 3 bytes) and are then
    // ignored, so the receiver is back in idle afterward.
    task automatic flush_to_idle();
        repeat (MAX_LEN + 3) drive_byte('0, 1'b0);
    endtask

    // Stops offering bytes and waits until every expected result has arrived.
    task automatic settle();
        rx_if.valid <= 1'b0;
        while (exp_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic program_regs(input logic [BYTE_W-1:0] src, input logic [BYTE_W-1:0] org,
                                input logic [BYTE_W-1:0] fwd, input logic [BYTE_W-1:0] rtr);
        write_reg(CFG_SOURCE_MASK, src);
        write_reg(CFG_ORIGIN_CODE, org);
        write_reg(CFG_ENDPOINT_MASK, fwd);
        write_reg(CFG_ROUTER_MASK, rtr);
        @(negedge clk);
        cfg_we  <= 1'b0;
        cur_src = src;
        cur_org = org;
        n_settings++;
    endtask

    initial
    begin : stimulus
        logic [BYTE_W-1:0] s;
        logic [BYTE_W-1:0] o;
        logic [BYTE_W-1:0] e;
        logic [BYTE_W-1:0] r;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        cur_src       = '0;
        cur_org       = '0;
        gap_en        = 1'b1;
        stall_en      = 1'b1;
        hold_req      = 1'b0;
        n_sent        = 0;
        n_settings    = 1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset register values.
        drive_byte(8'h00, 1'b0);
        drive_byte(8'hFF, 1'b0);
        drive_byte(SYNC1_BYTE, 1'b1);
        drive_byte(8'h00, 1'b1);
        // A second 0xAA aborts and is not taken as a new start, so 0x55 is noise.
        drive_byte(SYNC1_BYTE, 1'b1);
        drive_byte(SYNC1_BYTE, 1'b1);
        drive_byte(SYNC2_BYTE, 1'b0);
        drive_byte(SYNC1_BYTE, 1'b1);
        drive_byte(SYNC2_BYTE, 1'b1);
        drive_byte(BYTE_W'(MIN_SIZE - 1), 1'b1);
        drive_byte(SYNC1_BYTE, 1'b1);
        drive_byte(SYNC2_BYTE, 1'b1);
        drive_byte(BYTE_W'(MAX_LEN + 1), 1'b1);
        send_frame(2, 8'hFF, 1'b1, 0);
        send_frame(2, 8'h00, 1'b0, 0);
        settle();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    s = 8'hFF; o = 8'hFF; e = 8'hFF; r = 8'hFF;
                end
                1:
                begin
                    s = 8'hF0; o = 8'h35; e = 8'h01; r = 8'h02;
                end
                2:
                begin
                    s = 8'h0F; o = 8'hA0; e = 8'h80; r = 8'h80;
                end
                3:
                begin
                    s = 8'h00; o = 8'h00; e = 8'h00; r = 8'h00;
                end
                default:
                begin
                    s = BYTE_W'($urandom); o = BYTE_W'($urandom);
                    e = BYTE_W'($urandom); r = BYTE_W'($urandom);
                end
            endcase
            program_regs(s, o, e, r);
            if (ph == N_PHASES - 1)
            begin
                gap_en   = 1'b0;
                stall_en = 1'b0;
            end
            random_traffic(ITEMS_PER_PHASE, ph == 1 || ph == 4);
            flush_to_idle();
            settle();
        end

        $display("Checked %0d results: %0d good-CRC verdicts, %0d bad-CRC verdicts, %0d aborts.",
                 n_results, n_good, n_bad_crc, n_abort);
        $display("Frames ran under %0d register settings with idle bursts and long output stalls.",
                 n_settings);
        if (fail_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
